// File: hdl/gmdfc_pkg.sv
// Shared types, codes and helper functions for the grid maze carver.
`timescale 1ns / 1ps

package gmdfc_pkg;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 1'b1;

    localparam int GRID_WIDTH_RST  = 16;
    localparam int GRID_HEIGHT_RST = 12;

    // Request kinds
    localparam logic REQ_START = 1'b0;
    localparam logic REQ_STEP  = 1'b1;

    // Result actions
    localparam logic [2:0] ACT_STARTED     = 3'd0;
    localparam logic [2:0] ACT_CARVED      = 3'd1;
    localparam logic [2:0] ACT_BACKTRACKED = 3'd2;
    localparam logic [2:0] ACT_FINISHED    = 3'd3;
    localparam logic [2:0] ACT_NOT_STARTED = 3'd4;

    // Neighbour directions, in probe order
    localparam logic [1:0] DIR_MINUS_X = 2'd0;
    localparam logic [1:0] DIR_PLUS_X  = 2'd1;
    localparam logic [1:0] DIR_MINUS_Y = 2'd2;
    localparam logic [1:0] DIR_PLUS_Y  = 2'd3;

    typedef struct packed {
        logic        req_type;
        logic [15:0] random_value;
    } req_t;

    typedef struct packed {
        logic [2:0] action;
        logic [3:0] cell_x;
        logic [3:0] cell_y;
        logic [1:0] direction;
        logic [3:0] next_x;
        logic [3:0] next_y;
    } rsp_t;

    // Controller to datapath commands
    typedef struct packed {
        logic       accept;
        logic       clr_step;
        logic       start_done;
        logic       probe;
        logic       pair;
        logic       commit;
        logic       refuse;
        logic [2:0] refuse_act;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic started;
        logic stack_empty;
        logic clr_last;
    } sts_t;

    // Remainder of a 16-bit word by three: fold base-4 digits (4 is 1 mod 3)
    function automatic logic [1:0] mod3_16(input logic [15:0] v);
        logic [4:0] s;
        logic [3:0] t;
        logic [2:0] u;
        s = '0;
        for (int i = 0; i < 8; i++)
        begin
            s = s + 5'(v[2*i +: 2]);
        end
        t = 4'(s[4:2]) + 4'(s[1:0]);
        u = 3'(t[3:2]) + 3'(t[1:0]);
        if (u >= 3'd3)
        begin
            u = u - 3'd3;
        end
        return u[1:0];
    endfunction

    // Position of the p-th set bit of a four-bit mask
    function automatic logic [1:0] nth_set(input logic [3:0] mask, input logic [1:0] p);
        logic [1:0] sel;
        logic [2:0] seen;
        sel  = DIR_MINUS_X;
        seen = '0;
        for (int k = 0; k < 4; k++)
        begin
            if (mask[k])
            begin
                if (seen == {1'b0, p})
                begin
                    sel = 2'(k);
                end
                seen = seen + 3'd1;
            end
        end
        return sel;
    endfunction

endpackage

// File: hdl/gmdfc_ctrl.sv
// Controller state machine for the grid maze carver.
`timescale 1ns / 1ps

module gmdfc_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              req_type,
    input  gmdfc_pkg::sts_t   sts,
    output logic              busy,
    output gmdfc_pkg::cmd_t   cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CLEAR  = 3'd1;
    localparam logic [2:0] S_PROBE  = 3'd2;
    localparam logic [2:0] S_EVAL   = 3'd3;
    localparam logic [2:0] S_COMMIT = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign busy = (state_reg != S_IDLE);

    // Sequence each request
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.accept = 1'b1;
                    if (req_type == gmdfc_pkg::REQ_START)
                    begin
                        state_next = S_CLEAR;
                    end
                    else if (!sts.started)
                    begin
                        cmd.refuse     = 1'b1;
                        cmd.refuse_act = gmdfc_pkg::ACT_NOT_STARTED;
                    end
                    else if (sts.stack_empty)
                    begin
                        cmd.refuse     = 1'b1;
                        cmd.refuse_act = gmdfc_pkg::ACT_FINISHED;
                    end
                    else
                    begin
                        cmd.probe  = 1'b1;
                        cmd.pair   = 1'b0;
                        state_next = S_PROBE;
                    end
                end
            end
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    cmd.start_done = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_PROBE:
            begin
                cmd.probe  = 1'b1;
                cmd.pair   = 1'b1;
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: hdl/gmdfc_dpath.sv
// Datapath for the grid maze carver: position, visited map, walk stack, results.
`timescale 1ns / 1ps

module gmdfc_dpath
#(
    parameter int MAX_WIDTH  = 16,
    parameter int MAX_HEIGHT = 16
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  gmdfc_pkg::cmd_t                     cmd,
    output gmdfc_pkg::sts_t                     sts,
    input  logic [15:0]                         random_value,
    input  logic                                cfg_we,
    input  logic [gmdfc_pkg::CFG_IDX_W-1:0]     cfg_idx,
    input  logic [gmdfc_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic                                done,
    output gmdfc_pkg::rsp_t                     rsp
);

    localparam int XW     = $clog2(MAX_WIDTH);
    localparam int YW     = $clog2(MAX_HEIGHT);
    localparam int AW     = XW + YW;
    localparam int VDEPTH = 1 << AW;
    localparam int CELLS  = MAX_WIDTH * MAX_HEIGHT;
    localparam int SAW    = $clog2(CELLS);

    typedef logic [XW:0]    wdim_t;
    typedef logic [YW:0]    hdim_t;
    typedef logic [AW-1:0]  cell_t;
    typedef logic [SAW:0]   sptr_t;

    typedef struct packed {
        logic          ok;
        logic [XW-1:0] x;
        logic [YW-1:0] y;
    } nb_t;

    localparam wdim_t W_RST = wdim_t'((gmdfc_pkg::GRID_WIDTH_RST > MAX_WIDTH) ?
                                      MAX_WIDTH : gmdfc_pkg::GRID_WIDTH_RST);
    localparam hdim_t H_RST = hdim_t'((gmdfc_pkg::GRID_HEIGHT_RST > MAX_HEIGHT) ?
                                      MAX_HEIGHT : gmdfc_pkg::GRID_HEIGHT_RST);
    localparam sptr_t SP_FULL = sptr_t'(CELLS);

    // Saturate a written size into 1..MAX
    function automatic wdim_t clamp_w(input logic [gmdfc_pkg::CFG_DATA_W-1:0] v);
        wdim_t r;
        if (v == '0)
            r = wdim_t'(1);
        else if (int'(v) > MAX_WIDTH)
            r = wdim_t'(MAX_WIDTH);
        else
            r = wdim_t'(v);
        return r;
    endfunction

    function automatic hdim_t clamp_h(input logic [gmdfc_pkg::CFG_DATA_W-1:0] v);
        hdim_t r;
        if (v == '0)
            r = hdim_t'(1);
        else if (int'(v) > MAX_HEIGHT)
            r = hdim_t'(MAX_HEIGHT);
        else
            r = hdim_t'(v);
        return r;
    endfunction

    // Neighbour of a cell in one direction, and whether it lies in the grid
    function automatic nb_t nb_of(input logic [XW-1:0] x, input logic [YW-1:0] y,
                                  input logic [1:0] d, input wdim_t gw, input hdim_t gh);
        nb_t   r;
        wdim_t ex;
        hdim_t ey;
        logic  ok;
        ex = {1'b0, x};
        ey = {1'b0, y};
        ok = 1'b1;
        case (d)
            gmdfc_pkg::DIR_MINUS_X:
            begin
                ok = (x != '0);
                ex = ex - wdim_t'(1);
            end
            gmdfc_pkg::DIR_PLUS_X:
            begin
                ex = ex + wdim_t'(1);
            end
            gmdfc_pkg::DIR_MINUS_Y:
            begin
                ok = (y != '0);
                ey = ey - hdim_t'(1);
            end
            gmdfc_pkg::DIR_PLUS_Y:
            begin
                ey = ey + hdim_t'(1);
            end
            default:
            begin
                ok = 1'b0;
            end
        endcase
        r.ok = ok && (ex < gw) && (ey < gh);
        r.x  = ex[XW-1:0];
        r.y  = ey[YW-1:0];
        return r;
    endfunction

    // Registers
    wdim_t           grid_w_reg,  grid_w_next;
    hdim_t           grid_h_reg,  grid_h_next;
    logic [XW-1:0]   cur_x_reg,   cur_x_next;
    logic [YW-1:0]   cur_y_reg,   cur_y_next;
    sptr_t           sp_reg,      sp_next;
    logic            started_reg, started_next;
    logic [1:0]      rnd_lo_reg,  rnd_lo_next;
    logic [1:0]      rnd_m3_reg,  rnd_m3_next;
    cell_t           clr_cnt_reg, clr_cnt_next;
    logic            probe_d_reg, probe_d_next;
    logic            pair_d_reg,  pair_d_next;
    logic [1:0]      ok_d_reg,    ok_d_next;
    logic [3:0]      free_reg,    free_next;
    logic            done_reg,    done_next;
    gmdfc_pkg::rsp_t rsp_reg,     rsp_next;

    // Memories and their read data
    logic            vis_mem [VDEPTH];
    cell_t           stk_mem [CELLS];
    logic            vis_a_reg;
    logic            vis_b_reg;
    cell_t           stk_rd_reg;

    // Memory port controls
    logic            vis_we;
    cell_t           vis_waddr;
    logic            vis_wdata;
    logic            stk_we;
    logic [SAW-1:0]  stk_waddr;
    cell_t           stk_wdata;
    logic [SAW-1:0]  stk_raddr;

    // Probe and choice
    nb_t             nb_a;
    nb_t             nb_b;
    nb_t             nb_c;
    logic [2:0]      free_cnt;
    logic [1:0]      pick;
    logic [1:0]      dir_sel;

    assign sts.started     = started_reg;
    assign sts.stack_empty = (sp_reg == '0);
    assign sts.clr_last    = (clr_cnt_reg == '1);

    assign done = done_reg;
    assign rsp  = rsp_reg;

    // Probe two neighbours per cycle, choose one at commit
    always_comb
    begin
        nb_a     = nb_of(cur_x_reg, cur_y_reg, {cmd.pair, 1'b0}, grid_w_reg, grid_h_reg);
        nb_b     = nb_of(cur_x_reg, cur_y_reg, {cmd.pair, 1'b1}, grid_w_reg, grid_h_reg);
        free_cnt = 3'($countones(free_reg));
        case (free_cnt)
            3'd2:    pick = {1'b0, rnd_lo_reg[0]};
            3'd3:    pick = rnd_m3_reg;
            3'd4:    pick = rnd_lo_reg;
            default: pick = 2'd0;
        endcase
        dir_sel   = gmdfc_pkg::nth_set(free_reg, pick);
        nb_c      = nb_of(cur_x_reg, cur_y_reg, dir_sel, grid_w_reg, grid_h_reg);
        stk_raddr = (sp_reg == '0) ? '0 : SAW'(sp_reg - sptr_t'(1));
    end

    // Next state of the walk
    always_comb
    begin
        grid_w_next  = grid_w_reg;
        grid_h_next  = grid_h_reg;
        cur_x_next   = cur_x_reg;
        cur_y_next   = cur_y_reg;
        sp_next      = sp_reg;
        started_next = started_reg;
        rnd_lo_next  = rnd_lo_reg;
        rnd_m3_next  = rnd_m3_reg;
        clr_cnt_next = clr_cnt_reg;
        probe_d_next = 1'b0;
        pair_d_next  = pair_d_reg;
        ok_d_next    = ok_d_reg;
        free_next    = free_reg;
        done_next    = 1'b0;
        rsp_next     = rsp_reg;
        vis_we       = 1'b0;
        vis_waddr    = clr_cnt_reg;
        vis_wdata    = 1'b0;
        stk_we       = 1'b0;
        stk_waddr    = sp_reg[SAW-1:0];
        stk_wdata    = {nb_c.y, nb_c.x};

        // Configuration writes
        if (cfg_we)
        begin
            case (cfg_idx)
                gmdfc_pkg::CFG_GRID_WIDTH:  grid_w_next = clamp_w(cfg_data);
                gmdfc_pkg::CFG_GRID_HEIGHT: grid_h_next = clamp_h(cfg_data);
                default:                    grid_w_next = grid_w_reg;
            endcase
        end

        // Latch the random word for the choice
        if (cmd.accept)
        begin
            rnd_lo_next = random_value[1:0];
            rnd_m3_next = gmdfc_pkg::mod3_16(random_value);
        end

        // Clear sweep; cell (0,0) is marked visited on its way past
        if (cmd.clr_step)
        begin
            vis_we       = 1'b1;
            vis_waddr    = clr_cnt_reg;
            vis_wdata    = (clr_cnt_reg == '0);
            clr_cnt_next = clr_cnt_reg + cell_t'(1);
        end

        if (cmd.start_done)
        begin
            stk_we       = 1'b1;
            stk_waddr    = '0;
            stk_wdata    = '0;
            sp_next      = sptr_t'(1);
            started_next = 1'b1;
            cur_x_next   = '0;
            cur_y_next   = '0;
            done_next    = 1'b1;
            rsp_next.action    = gmdfc_pkg::ACT_STARTED;
            rsp_next.cell_x    = 4'(cur_x_reg);
            rsp_next.cell_y    = 4'(cur_y_reg);
            rsp_next.direction = gmdfc_pkg::DIR_MINUS_X;
            rsp_next.next_x    = '0;
            rsp_next.next_y    = '0;
        end

        // Step with nothing to do: report and leave the state
        if (cmd.refuse)
        begin
            done_next          = 1'b1;
            rsp_next.action    = cmd.refuse_act;
            rsp_next.cell_x    = 4'(cur_x_reg);
            rsp_next.cell_y    = 4'(cur_y_reg);
            rsp_next.direction = gmdfc_pkg::DIR_MINUS_X;
            rsp_next.next_x    = 4'(cur_x_reg);
            rsp_next.next_y    = 4'(cur_y_reg);
        end

        // Issue a probe pair; gather its visited bits in the cycle after
        if (cmd.probe)
        begin
            probe_d_next = 1'b1;
            pair_d_next  = cmd.pair;
            ok_d_next    = {nb_b.ok, nb_a.ok};
        end
        if (probe_d_reg)
        begin
            if (pair_d_reg)
                free_next[3:2] = {ok_d_reg[1] & ~vis_b_reg, ok_d_reg[0] & ~vis_a_reg};
            else
                free_next[1:0] = {ok_d_reg[1] & ~vis_b_reg, ok_d_reg[0] & ~vis_a_reg};
        end

        // Carve into the chosen neighbour, or pop back
        if (cmd.commit)
        begin
            done_next       = 1'b1;
            rsp_next.cell_x = 4'(cur_x_reg);
            rsp_next.cell_y = 4'(cur_y_reg);
            if (free_cnt != 3'd0)
            begin
                vis_we    = 1'b1;
                vis_waddr = {nb_c.y, nb_c.x};
                vis_wdata = 1'b1;
                if (sp_reg < SP_FULL)
                begin
                    stk_we    = 1'b1;
                    stk_waddr = sp_reg[SAW-1:0];
                    stk_wdata = {nb_c.y, nb_c.x};
                    sp_next   = sp_reg + sptr_t'(1);
                end
                cur_x_next         = nb_c.x;
                cur_y_next         = nb_c.y;
                rsp_next.action    = gmdfc_pkg::ACT_CARVED;
                rsp_next.direction = dir_sel;
                rsp_next.next_x    = 4'(nb_c.x);
                rsp_next.next_y    = 4'(nb_c.y);
            end
            else
            begin
                sp_next            = sp_reg - sptr_t'(1);
                cur_x_next         = stk_rd_reg[XW-1:0];
                cur_y_next         = stk_rd_reg[AW-1:XW];
                rsp_next.action    = gmdfc_pkg::ACT_BACKTRACKED;
                rsp_next.direction = gmdfc_pkg::DIR_MINUS_X;
                rsp_next.next_x    = 4'(stk_rd_reg[XW-1:0]);
                rsp_next.next_y    = 4'(stk_rd_reg[AW-1:XW]);
            end
        end
    end

    // Hold the walk state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_w_reg  <= W_RST;
            grid_h_reg  <= H_RST;
            cur_x_reg   <= '0;
            cur_y_reg   <= '0;
            sp_reg      <= '0;
            started_reg <= 1'b0;
            rnd_lo_reg  <= '0;
            rnd_m3_reg  <= '0;
            clr_cnt_reg <= '0;
            probe_d_reg <= 1'b0;
            pair_d_reg  <= 1'b0;
            ok_d_reg    <= '0;
            free_reg    <= '0;
            done_reg    <= 1'b0;
            rsp_reg     <= '0;
        end
        else
        begin
            grid_w_reg  <= grid_w_next;
            grid_h_reg  <= grid_h_next;
            cur_x_reg   <= cur_x_next;
            cur_y_reg   <= cur_y_next;
            sp_reg      <= sp_next;
            started_reg <= started_next;
            rnd_lo_reg  <= rnd_lo_next;
            rnd_m3_reg  <= rnd_m3_next;
            clr_cnt_reg <= clr_cnt_next;
            probe_d_reg <= probe_d_next;
            pair_d_reg  <= pair_d_next;
            ok_d_reg    <= ok_d_next;
            free_reg    <= free_next;
            done_reg    <= done_next;
            rsp_reg     <= rsp_next;
        end
    end

    // Visited map: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (vis_we)
        begin
            vis_mem[vis_waddr] <= vis_wdata;
        end
        vis_a_reg <= vis_mem[{nb_a.y, nb_a.x}];
        vis_b_reg <= vis_mem[{nb_b.y, nb_b.x}];
    end

    // Walk stack: top entry is read every cycle
    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stk_mem[stk_waddr] <= stk_wdata;
        end
        stk_rd_reg <= stk_mem[stk_raddr];
    end

endmodule

// File: hdl/grid_maze_depth_first_carver_top.sv
// Step request: the visited map is probed for two pairs of neighbours, then the choice
// is evaluated and committed; no new request is taken while busy.
// Start request: clears the visited map one entry a cycle, all 2**(XW+YW) entries (256 by
// default), then the result is taken; a refused step answers in the cycle after acceptance.
// Reset clears position, stack count, started flag and grid size (16 x 12); the map
// and stack memories are not reset. Results are never held off by the receiver.
`timescale 1ns / 1ps

module grid_maze_depth_first_carver_top
#(
    parameter int MAX_WIDTH  = 16,
    parameter int MAX_HEIGHT = 16
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  gmdfc_pkg::req_t                     req,
    output logic                                busy,
    output logic                                done,
    output gmdfc_pkg::rsp_t                     rsp,
    input  logic                                cfg_we,
    input  logic [gmdfc_pkg::CFG_IDX_W-1:0]     cfg_idx,
    input  logic [gmdfc_pkg::CFG_DATA_W-1:0]    cfg_data
);

    gmdfc_pkg::cmd_t cmd;
    gmdfc_pkg::sts_t sts;

    // Sequence requests
    gmdfc_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (req.req_type),
        .sts      (sts),
        .busy     (busy),
        .cmd      (cmd)
    );

    // Walk state and memories
    gmdfc_dpath
    #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    )
    u_dpath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .random_value (req.random_value),
        .cfg_we       (cfg_we),
        .cfg_idx      (cfg_idx),
        .cfg_data     (cfg_data),
        .done         (done),
        .rsp          (rsp)
    );

endmodule

// File: tb/tb_grid_maze_depth_first_carver_top.sv
// Self-checking testbench for the grid maze depth-first carver: random walks, resizes, backtracks.
`timescale 1ns / 1ps

module tb_grid_maze_depth_first_carver_top;

    localparam int QUIET_LIMIT = 3000;
    localparam int ITEM_TARGET = 1600;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             start = 1'b0;
    gmdfc_pkg::req_t                  req = '0;
    logic                             busy;
    logic                             done;
    gmdfc_pkg::rsp_t                  rsp;
    logic                             cfg_we = 1'b0;
    logic [gmdfc_pkg::CFG_IDX_W-1:0]  cfg_idx = '0;
    logic [gmdfc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    // Bench's model of the carver's maze
    logic       visited_cells [256];
    logic [7:0] trail [256];
    logic [8:0] trail_depth;
    logic [7:0] here_cell;
    logic       walk_started;
    logic [4:0] cols_reg;
    logic [4:0] rows_reg;

    gmdfc_pkg::req_t req_backlog [$];
    gmdfc_pkg::rsp_t moves_due [$];
    logic req_taken = 1'b0;
    int   idle_left = 0;
    logic no_idle = 1'b0;
    int   fails = 0;
    int   quiet_cycles = 0;
    int   sent = 0;

    grid_maze_depth_first_carver_top DUT
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req      (req),
        .busy     (busy),
        .done     (done),
        .rsp      (rsp),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Saturate a grid dimension register into 1..16
    function automatic int dim_used(input logic [4:0] v);
        if (v == 5'd0)
        begin
            return 1;
        end
        if (v > 5'd16)
        begin
            return 16;
        end
        return int'(v);
    endfunction

    // Advance the maze by one request and return the move it should report
    function automatic gmdfc_pkg::rsp_t walk_one(input gmdfc_pkg::req_t r);
        gmdfc_pkg::rsp_t o;
        logic [7:0] from;
        int         w;
        int         h;
        int         cx;
        int         cy;
        int         nx;
        int         ny;
        int         n;
        int         pick;
        logic [7:0] cand [4];
        logic [1:0] cdir [4];
        o      = '0;
        from   = here_cell;
        o.cell_x = from[3:0];
        o.cell_y = from[7:4];
        if (r.req_type == gmdfc_pkg::REQ_START)
        begin
            foreach (visited_cells[i])
            begin
                visited_cells[i] = 1'b0;
            end
            visited_cells[0] = 1'b1;
            trail[0]     = 8'd0;
            trail_depth  = 9'd1;
            here_cell    = 8'd0;
            walk_started = 1'b1;
            o.action     = gmdfc_pkg::ACT_STARTED;
        end
        else if (!walk_started)
        begin
            o.action = gmdfc_pkg::ACT_NOT_STARTED;
        end
        else if (trail_depth == 9'd0)
        begin
            o.action = gmdfc_pkg::ACT_FINISHED;
        end
        else
        begin
            w  = dim_used(cols_reg);
            h  = dim_used(rows_reg);
            cx = int'(from[3:0]);
            cy = int'(from[7:4]);
            n  = 0;
            // Probe neighbours in the fixed order -x, +x, -y, +y
            for (int k = 0; k < 4; k++)
            begin
                nx = cx;
                ny = cy;
                if (2'(k) == gmdfc_pkg::DIR_MINUS_X)
                begin
                    nx = cx - 1;
                end
                else if (2'(k) == gmdfc_pkg::DIR_PLUS_X)
                begin
                    nx = cx + 1;
                end
                else if (2'(k) == gmdfc_pkg::DIR_MINUS_Y)
                begin
                    ny = cy - 1;
                end
                else
                begin
                    ny = cy + 1;
                end
                if (nx >= 0 && ny >= 0 && nx < w && ny < h)
                begin
                    if (!visited_cells[8'(ny*16 + nx)])
                    begin
                        cand[2'(n)] = 8'(ny*16 + nx);
                        cdir[2'(n)] = 2'(k);
                        n++;
                    end
                end
            end
            if (n > 0)
            begin
                pick = int'(r.random_value) % n;
                visited_cells[cand[2'(pick)]] = 1'b1;
                if (trail_depth < 9'd256)
                begin
                    trail[trail_depth[7:0]] = cand[2'(pick)];
                    trail_depth = trail_depth + 9'd1;
                end
                here_cell   = cand[2'(pick)];
                o.action    = gmdfc_pkg::ACT_CARVED;
                o.direction = cdir[2'(pick)];
            end
            else
            begin
                trail_depth = trail_depth - 9'd1;
                here_cell   = trail[trail_depth[7:0]];
                o.action    = gmdfc_pkg::ACT_BACKTRACKED;
            end
        end
        o.next_x = here_cell[3:0];
        o.next_y = here_cell[7:4];
        return o;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fails++;
        end
    endtask

    // Check finished moves, track register writes, predict accepted requests
    always @(posedge clk)
    begin
        gmdfc_pkg::rsp_t due;
        if (!rst_n)
        begin
            cols_reg     <= 5'(gmdfc_pkg::GRID_WIDTH_RST);
            rows_reg     <= 5'(gmdfc_pkg::GRID_HEIGHT_RST);
            trail_depth  = 9'd0;
            here_cell    = 8'd0;
            walk_started = 1'b0;
            req_taken    <= 1'b0;
        end
        else
        begin
            if (done)
            begin
                if (moves_due.size() == 0)
                begin
                    $error("unexpected result: action %0d", rsp.action);
                    fails++;
                end
                else
                begin
                    due = moves_due.pop_front();
                    check_field("action", int'(due.action), int'(rsp.action));
                    check_field("cell_x", int'(due.cell_x), int'(rsp.cell_x));
                    check_field("cell_y", int'(due.cell_y), int'(rsp.cell_y));
                    check_field("direction", int'(due.direction), int'(rsp.direction));
                    check_field("next_x", int'(due.next_x), int'(rsp.next_x));
                    check_field("next_y", int'(due.next_y), int'(rsp.next_y));
                end
            end
            if (cfg_we)
            begin
                if (cfg_idx == gmdfc_pkg::CFG_GRID_WIDTH)
                begin
                    cols_reg <= cfg_data;
                end
                else
                begin
                    rows_reg <= cfg_data;
                end
            end
            if (start && !busy)
            begin
                moves_due = {moves_due, walk_one(req)};
            end
            req_taken <= start && !busy;
        end
    end

    // Present requests from the backlog, with random gaps between them
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else if (start && !req_taken)
        begin
            // hold the request until the block takes it
        end
        else if (idle_left > 0)
        begin
            start     <= 1'b0;
            idle_left <= idle_left - 1;
        end
        else if (req_backlog.size() > 0)
        begin
            req   <= req_backlog.pop_front();
            start <= 1'b1;
            if ($urandom_range(0, 63) == 0)
            begin
                no_idle <= !no_idle;
            end
            idle_left <= no_idle ? 0 : $urandom_range(0, 15);
        end
        else
        begin
            start <= 1'b0;
        end
    end

    // End the run if nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("grid_maze_depth_first_carver_top verification failed");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic queue_req(input logic kind, input logic [15:0] rnd);
        gmdfc_pkg::req_t r;
        r.req_type     = kind;
        r.random_value = rnd;
        req_backlog    = {req_backlog, r};
        sent++;
    endtask

    task automatic queue_steps(input int count);
        logic [15:0] rnd;
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(0, 9))
                0:       rnd = 16'h0000;
                1:       rnd = 16'hFFFF;
                default: rnd = 16'($urandom_range(0, 65535));
            endcase
            queue_req(gmdfc_pkg::REQ_STEP, rnd);
        end
    endtask

    // Trim a run of steps to what is left of the item budget
    function automatic int trim_steps(input int want);
        int left;
        left = ITEM_TARGET - sent;
        if (left < 1)
        begin
            left = 1;
        end
        return (want < left) ? want : left;
    endfunction

    // Wait until every request has been taken and answered
    task automatic drain();
        @(posedge clk);
        while (req_backlog.size() != 0 || start || moves_due.size() != 0 || busy)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [gmdfc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [4:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we   <= 1'b0;
        @(negedge clk);
    endtask

    // Mostly small grids, now and then large or out of range
    function automatic logic [4:0] pick_dim();
        case ($urandom_range(0, 19))
            0:       return 5'($urandom_range(0, 1));
            1:       return 5'($urandom_range(17, 31));
            2, 3:    return 5'($urandom_range(7, 16));
            default: return 5'($urandom_range(2, 6));
        endcase
    endfunction

    initial
    begin
        logic [4:0] w;
        logic [4:0] h;
        int         cells;
        int         steps;
        int         first;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Steps before any start, then a short walk on the reset grid
        queue_req(gmdfc_pkg::REQ_STEP, 16'h0000);
        queue_req(gmdfc_pkg::REQ_STEP, 16'hFFFF);
        queue_req(gmdfc_pkg::REQ_START, 16'hFFFF);
        queue_steps(4);
        drain();

        // Resize mid-walk to a single oversaturated row
        write_reg(gmdfc_pkg::CFG_GRID_WIDTH, 5'd31);
        write_reg(gmdfc_pkg::CFG_GRID_HEIGHT, 5'd0);
        queue_steps(3);
        drain();

        // Tiny grid walked to the end, then reported finished
        write_reg(gmdfc_pkg::CFG_GRID_WIDTH, 5'd2);
        write_reg(gmdfc_pkg::CFG_GRID_HEIGHT, 5'd2);
        queue_req(gmdfc_pkg::REQ_START, 16'h0000);
        queue_steps(8);
        drain();

        // Single column, height saturated
        write_reg(gmdfc_pkg::CFG_GRID_WIDTH, 5'd1);
        write_reg(gmdfc_pkg::CFG_GRID_HEIGHT, 5'd17);
        queue_req(gmdfc_pkg::REQ_START, 16'h5A5A);
        queue_steps(3);

        // Random walks: mostly whole mazes, some cut short, resized or noisy
        while (sent < ITEM_TARGET)
        begin
            drain();
            w = pick_dim();
            h = pick_dim();
            if ($urandom_range(0, 3) != 0)
            begin
                write_reg(gmdfc_pkg::CFG_GRID_WIDTH, w);
                write_reg(gmdfc_pkg::CFG_GRID_HEIGHT, h);
            end
            else if ($urandom_range(0, 1) == 0)
            begin
                write_reg(gmdfc_pkg::CFG_GRID_WIDTH, w);
            end
            else
            begin
                write_reg(gmdfc_pkg::CFG_GRID_HEIGHT, h);
            end
            cells = dim_used(cols_reg) * dim_used(rows_reg);
            steps = 2 * cells + $urandom_range(0, 3);
            if ($urandom_range(0, 5) == 0)
            begin
                steps = $urandom_range(1, 2 * cells);
            end
            queue_req(gmdfc_pkg::REQ_START, 16'($urandom_range(0, 65535)));
            steps = trim_steps(steps);
            if ($urandom_range(0, 4) == 0)
            begin
                // Change the grid partway through the walk
                first = $urandom_range(1, steps);
                queue_steps(first);
                drain();
                write_reg(gmdfc_pkg::CFG_GRID_WIDTH, pick_dim());
                write_reg(gmdfc_pkg::CFG_GRID_HEIGHT, pick_dim());
                cells = dim_used(cols_reg) * dim_used(rows_reg);
                queue_steps(trim_steps(2 * cells + 2));
            end
            else
            begin
                queue_steps(steps);
            end
            if ($urandom_range(0, 9) == 0)
            begin
                // Noise: requests of random kind
                repeat ($urandom_range(1, 6))
                begin
                    queue_req(1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)));
                end
            end
        end

        drain();
        repeat (16) @(posedge clk);
        if (fails == 0)
        begin
            $display("grid_maze_depth_first_carver_top verification clean");
        end
        else
        begin
            $display("grid_maze_depth_first_carver_top verification failed");
        end
        $finish;
    end

endmodule

// File: grid_maze_depth_first_carver_top.f
hdl/gmdfc_pkg.sv
hdl/gmdfc_ctrl.sv
hdl/gmdfc_dpath.sv
hdl/grid_maze_depth_first_carver_top.sv
tb/tb_grid_maze_depth_first_carver_top.sv
